FILE: hdl/fast_atan2_approx_defines.svh
// Assertion macros used by the fast_atan2_approx checker.
`ifndef FAST_ATAN2_APPROX_DEFINES_SVH
`define FAST_ATAN2_APPROX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FA2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FA2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fa2_pkg.sv
// Types and constants of the fast atan2 approximation block.
`default_nettype none

package fa2_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    // magnitude of a coordinate, up to 2^(COORD_WIDTH-1)
    localparam int MAG_W  = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * MAG_W;
    // 25*c^2 + 7*d^2 <= 32 * 2^(2*COORD_WIDTH-2)
    localparam int DEN_W  = 2 * COORD_WIDTH + 4;
    // rounded dividend 2*num + den
    localparam int NUM_W  = 2 * COORD_WIDTH + 5 + ANGLE_FRAC_BITS;
    // rounded divisor 2*den
    localparam int DIV_W  = DEN_W + 1;
    // quotient stays below 2^ANGLE_FRAC_BITS
    localparam int QUO_W  = ANGLE_FRAC_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_RND =
        (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI_RND =
        (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);

    localparam logic signed [ANGLE_WIDTH-1:0] PI_FX      = PI_RND[ANGLE_WIDTH-1:0];
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_FX = HALF_PI_RND[ANGLE_WIDTH-1:0];

    // One division job: angle = base +/- round(dividend / divisor).
    typedef struct packed {
        logic [NUM_W-1:0]              dividend;
        logic [DIV_W-1:0]              divisor;
        logic signed [ANGLE_WIDTH-1:0] base;
        logic                          negate;
        logic                          zero_q;
    } fa2_job_t;

endpackage

`default_nettype wire

FILE: hdl/fa2_vec_if.sv
// Channel that carries one input vector (y, x).
`default_nettype none

interface fa2_vec_if
    import fa2_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] x_coord;

    modport source (output valid, output y_coord, output x_coord, input ready);
    modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

`default_nettype wire

FILE: hdl/fa2_angle_if.sv
// Channel that carries one result angle.
`default_nettype none

interface fa2_angle_if
    import fa2_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: hdl/fa2_front.sv
// Front end: classifies each vector and forms the dividend and divisor of its quotient.
`default_nettype none

module fa2_front
    import fa2_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fa2_vec_if.sink   vec,
    output logic      job_valid,
    output fa2_job_t  job,
    input  logic      job_ready
);

    logic                    adv;
    logic                    y_neg;
    logic                    x_neg;
    logic signed [MAG_W-1:0] y_ext;
    logic signed [MAG_W-1:0] x_ext;
    logic [MAG_W-1:0]        ay;
    logic [MAG_W-1:0]        ax;

    // stage 1: classification
    logic                          s1_valid_reg;
    logic [MAG_W-1:0]              ax_reg;
    logic [MAG_W-1:0]              ay_reg;
    logic [MAG_W-1:0]              c_reg;
    logic [MAG_W-1:0]              d_reg;
    logic signed [ANGLE_WIDTH-1:0] base1_reg;
    logic                          negate1_reg;
    logic                          zero_q1_reg;
    logic [MAG_W-1:0]              c_next;
    logic [MAG_W-1:0]              d_next;
    logic signed [ANGLE_WIDTH-1:0] base1_next;
    logic                          negate1_next;
    logic                          zero_q1_next;

    // stage 2: products
    logic                          s2_valid_reg;
    logic [PROD_W-1:0]             ab_reg;
    logic [PROD_W-1:0]             cc_reg;
    logic [PROD_W-1:0]             dd_reg;
    logic signed [ANGLE_WIDTH-1:0] base2_reg;
    logic                          negate2_reg;
    logic                          zero_q2_reg;

    // stage 3: scaled terms
    logic                          s3_valid_reg;
    fa2_job_t                      job_reg;
    fa2_job_t                      job_next;
    logic [DEN_W-1:0]              cc_w;
    logic [DEN_W-1:0]              dd_w;
    logic [DEN_W-1:0]              den;
    logic [NUM_W-1:0]              ab_w;
    logic [NUM_W-1:0]              num;

    // whole front advances unless the last stage is blocked
    assign adv       = !s3_valid_reg || job_ready;
    assign vec.ready = adv;
    assign job_valid = s3_valid_reg;
    assign job       = job_reg;

    assign y_neg = vec.y_coord[COORD_WIDTH-1];
    assign x_neg = vec.x_coord[COORD_WIDTH-1];
    assign y_ext = MAG_W'(vec.y_coord);
    assign x_ext = MAG_W'(vec.x_coord);
    assign ay    = y_neg ? MAG_W'(-y_ext) : MAG_W'(y_ext);
    assign ax    = x_neg ? MAG_W'(-x_ext) : MAG_W'(x_ext);

    always_comb
    begin
        c_next       = ay;
        d_next       = ax;
        base1_next   = '0;
        negate1_next = 1'b0;
        zero_q1_next = 1'b0;
        if (ax == '0)
        begin
            zero_q1_next = 1'b1;
            if (ay != '0)
            begin
                base1_next = y_neg ? -HALF_PI_FX : HALF_PI_FX;
            end
        end
        else if (ay < ax)
        begin
            // angle = q, shifted by pi into the left half-plane
            c_next       = ax;
            d_next       = ay;
            negate1_next = (x_neg != y_neg);
            if (x_neg)
            begin
                base1_next = y_neg ? -PI_FX : PI_FX;
            end
        end
        else
        begin
            // angle = pi/2 - q, less pi below the x axis
            c_next       = ay;
            d_next       = ax;
            negate1_next = (x_neg == y_neg);
            base1_next   = y_neg ? ANGLE_WIDTH'(HALF_PI_FX - PI_FX) : HALF_PI_FX;
        end
    end

    // 25*c^2 + 7*d^2 and 25*a*b*2^F, wrapping intermediate sums are harmless
    assign cc_w = DEN_W'(cc_reg);
    assign dd_w = DEN_W'(dd_reg);
    assign den  = (cc_w << 4) + (cc_w << 3) + cc_w + (dd_w << 3) - dd_w;
    assign ab_w = NUM_W'(ab_reg);
    assign num  = ((ab_w << 4) + (ab_w << 3) + ab_w) << ANGLE_FRAC_BITS;

    always_comb
    begin
        job_next.dividend = (num << 1) + NUM_W'(den);
        job_next.divisor  = {den, 1'b0};
        job_next.base     = base2_reg;
        job_next.negate   = negate2_reg;
        job_next.zero_q   = zero_q2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= vec.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg      <= ax;
            ay_reg      <= ay;
            c_reg       <= c_next;
            d_reg       <= d_next;
            base1_reg   <= base1_next;
            negate1_reg <= negate1_next;
            zero_q1_reg <= zero_q1_next;

            ab_reg      <= ax_reg * ay_reg;
            cc_reg      <= c_reg * c_reg;
            dd_reg      <= d_reg * d_reg;
            base2_reg   <= base1_reg;
            negate2_reg <= negate1_reg;
            zero_q2_reg <= zero_q1_reg;

            job_reg     <= job_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fa2_queue.sv
// Short job queue between the front end and the divider.
`default_nettype none

module fa2_queue
    import fa2_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    input  fa2_job_t push_job,
    output logic     push_ready,
    output logic     pop_valid,
    output fa2_job_t pop_job,
    input  logic     pop_ready
);

    fa2_job_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fa2_back.sv
// Back end: pipelined restoring divider, one quotient bit a stage, then sum and clamp.
`default_nettype none

module fa2_back
    import fa2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  fa2_job_t    job,
    output logic        job_ready,
    fa2_angle_if.source result
);

    logic                          adv;
    logic [QUO_W:0]                valid_reg;
    logic [QUO_W:0]                valid_next;
    logic [DIV_W-1:0]              rem_reg     [QUO_W+1];
    logic [DIV_W-1:0]              rem_next    [QUO_W+1];
    logic [QUO_W-1:0]              low_reg     [QUO_W+1];
    logic [QUO_W-1:0]              low_next    [QUO_W+1];
    logic [QUO_W-1:0]              quo_reg     [QUO_W+1];
    logic [QUO_W-1:0]              quo_next    [QUO_W+1];
    logic [DIV_W-1:0]              div_reg     [QUO_W+1];
    logic [DIV_W-1:0]              div_next    [QUO_W+1];
    logic signed [ANGLE_WIDTH-1:0] base_reg    [QUO_W+1];
    logic signed [ANGLE_WIDTH-1:0] base_next   [QUO_W+1];
    logic [QUO_W:0]                negate_reg;
    logic [QUO_W:0]                negate_next;
    logic [QUO_W:0]                zero_q_reg;
    logic [QUO_W:0]                zero_q_next;
    logic [DIV_W:0]                trial       [QUO_W];

    logic signed [ANGLE_WIDTH:0]   q_ext;
    logic signed [ANGLE_WIDTH:0]   term;
    logic signed [ANGLE_WIDTH:0]   sum;
    logic                          out_valid_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_next;

    // the divider and output register advance together; a held result stalls them
    assign adv          = !out_valid_reg || result.ready;
    assign job_ready    = adv;
    assign result.valid = out_valid_reg;
    assign result.angle = angle_reg;

    always_comb
    begin
        valid_next[0]  = job_valid;
        rem_next[0]    = DIV_W'(job.dividend[NUM_W-1:QUO_W]);
        low_next[0]    = job.dividend[QUO_W-1:0];
        quo_next[0]    = '0;
        div_next[0]    = job.divisor;
        base_next[0]   = job.base;
        negate_next[0] = job.negate;
        zero_q_next[0] = job.zero_q;
        for (int i = 0; i < QUO_W; i++)
        begin
            trial[i]         = {rem_reg[i], low_reg[i][QUO_W-1]};
            valid_next[i+1]  = valid_reg[i];
            low_next[i+1]    = low_reg[i] << 1;
            div_next[i+1]    = div_reg[i];
            base_next[i+1]   = base_reg[i];
            negate_next[i+1] = negate_reg[i];
            zero_q_next[i+1] = zero_q_reg[i];
            if (trial[i] >= {1'b0, div_reg[i]})
            begin
                rem_next[i+1] = DIV_W'(trial[i] - {1'b0, div_reg[i]});
                quo_next[i+1] = {quo_reg[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i+1] = DIV_W'(trial[i]);
                quo_next[i+1] = {quo_reg[i][QUO_W-2:0], 1'b0};
            end
        end
    end

    // add the signed quotient (none when zero_q is set) to the quadrant base and hold the sum within +-pi
    always_comb
    begin
        q_ext = (ANGLE_WIDTH + 1)'(quo_reg[QUO_W]);
        if (zero_q_reg[QUO_W])
        begin
            term = '0;
        end
        else if (negate_reg[QUO_W])
        begin
            term = -q_ext;
        end
        else
        begin
            term = q_ext;
        end
        sum = (ANGLE_WIDTH + 1)'(base_reg[QUO_W]) + term;
        if (sum > PI_FX)
        begin
            angle_next = PI_FX;
        end
        else if (sum < -PI_FX)
        begin
            angle_next = -PI_FX;
        end
        else
        begin
            angle_next = ANGLE_WIDTH'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                quo_reg[i]  <= quo_next[i];
                div_reg[i]  <= div_next[i];
                base_reg[i] <= base_next[i];
            end
            negate_reg <= negate_next;
            zero_q_reg <= zero_q_next;
            angle_reg  <= angle_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fast_atan2_approx.sv
// Top level of the fast atan2 approximation block.
//
// Channels: vec carries a signed vector (y_coord, x_coord); result carries its
// angle in radians, signed with 13 fraction bits, held within +-pi. Both use
// valid/ready; a transfer happens on a rising edge with valid and ready high.
// One angle comes out for every vector, in order.
// Path from the vector's transfer to the angle showing on result.valid:
// 3 front stages (classify, multiply, scale), the job queue, 15 divider
// stages and the output register. The quotient is built one bit a stage
// by the divider pipeline.
// Throughput: one vector per cycle, sustained while result.ready stays high.
// A four-entry queue sits between the front end and the divider; a stalled
// receiver holds the divider, the queue fills, and only then does vec.ready
// fall. A waiting result stays stable until taken.
// Reset (rst_n low, asynchronous) empties every stage and the queue; vec.ready
// is high from the first cycle after reset.
`default_nettype none

module fast_atan2_approx
    import fa2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fa2_vec_if.sink     vec,
    fa2_angle_if.source result
);

    logic     front_valid;
    fa2_job_t front_job;
    logic     front_ready;
    logic     back_valid;
    fa2_job_t back_job;
    logic     back_ready;

    fa2_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec       (vec),
        .job_valid (front_valid),
        .job       (front_job),
        .job_ready (front_ready)
    );

    fa2_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_job   (front_job),
        .push_ready (front_ready),
        .pop_valid  (back_valid),
        .pop_job    (back_job),
        .pop_ready  (back_ready)
    );

    fa2_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job       (back_job),
        .job_ready (back_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: hdl/fa2_checker.sv
// Port-level checker for fast_atan2_approx and its bind.
`default_nettype none
`include "fast_atan2_approx_defines.svh"

module fa2_checker
    import fa2_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [ANGLE_WIDTH-1:0] angle
);

    localparam int PEND_W      = 6;
    localparam int MIN_BACKLOG = QUEUE_DEPTH + 1;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              in_xfer;
    logic              out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // vectors taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `FA2_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle),
        "result changed while stalled")
    `FA2_ASSERT_NOW(a_angle_range, out_valid, (angle <= PI_FX) && (angle >= -PI_FX),
        "angle outside +-pi")
    `FA2_ASSERT_NOW(a_no_orphan, out_valid, pending_reg != '0,
        "result without a pending vector")
    `FA2_ASSERT_NOW(a_backlog, !in_ready, pending_reg >= PEND_W'(MIN_BACKLOG),
        "input stalled with the queue not full")

endmodule

bind fast_atan2_approx fa2_checker u_fa2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec.valid),
    .in_ready  (vec.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .angle     (result.angle)
);

`default_nettype wire
